// ===== rtl/kctk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kctk_pkg: shared types and constants
// Field widths, opcodes, register indexes and the ranking entry type used by
// the keyword counter and its ranking cells.
// ----------------------------------------------------------------------------
package kctk_pkg;

	localparam int TOP_K         = 5;
	localparam int MAX_KEYWORD   = 16;
	localparam int MAX_DOCUMENTS = 1024;

	localparam int DOC_W   = $clog2(MAX_DOCUMENTS + 1);
	localparam int CNT_W   = 16;
	localparam int POS_W   = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1;
	localparam int LEN_W   = 5;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 2;
	localparam int OP_W    = 2;
	localparam int KW_BITS = 8 * 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [DOC_W-1:0] DOC_LIMIT = DOC_W'(MAX_DOCUMENTS);

	localparam logic [OP_W-1:0] OP_TEXT   = 2'd0;
	localparam logic [OP_W-1:0] OP_EOD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

	localparam logic [IDX_W-1:0] REG_KW_LOW  = 2'd0;
	localparam logic [IDX_W-1:0] REG_KW_HIGH = 2'd1;
	localparam logic [IDX_W-1:0] REG_KW_LEN  = 2'd2;

	typedef struct packed {
		logic [DOC_W-1:0] doc;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// Command broadcast to every ranking cell.
	typedef struct packed {
		logic   ins;
		logic   clr;
		entry_t entry;
	} rank_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/kctk_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kctk_matcher: keyword occurrence counter
// Restart matcher over one text byte per cycle with a saturating count of
// keyword hits in the current document.
// ----------------------------------------------------------------------------
module kctk_matcher import kctk_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [KW_BITS-1:0] keyword,
	input  wire logic [LEN_W-1:0]   keyword_len,
	input  wire logic               byte_en,
	input  wire logic [7:0]         byte_in,
	input  wire logic               doc_clr,
	output      logic [CNT_W-1:0]   running_count
);

	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] eff_len;
	logic [POS_W-1:0] pos;
	logic [7:0]       kw_char;
	logic             hit;
	logic             at_end;

	always_comb begin
		if (keyword_len == '0) begin
			eff_len = LEN_W'(1);
		end else if (keyword_len > LEN_W'(MAX_KEYWORD)) begin
			eff_len = LEN_W'(MAX_KEYWORD);
		end else begin
			eff_len = keyword_len;
		end
		// A position left over from a longer keyword restarts at zero.
		pos     = (LEN_W'(pos_q) >= eff_len) ? '0 : pos_q;
		kw_char = keyword[{pos, 3'b000} +: 8];
		hit     = (byte_in == kw_char);
		at_end  = (LEN_W'(pos) == eff_len - LEN_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else if (doc_clr) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else if (byte_en) begin
			if (hit && at_end) begin
				pos_q <= '0;
				if (cnt_q != COUNT_MAX) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (hit) begin
				pos_q <= pos + POS_W'(1);
			end else begin
				pos_q <= '0;
			end
		end
	end

	assign running_count = cnt_q;

endmodule
`default_nettype wire

// ===== rtl/kctk_rank_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kctk_rank_cell: one slot of the sorted ranking
// Holds one (document, count) entry. On insertion the cell takes the new
// entry, shifts in its left neighbor's entry, or keeps its own.
// ----------------------------------------------------------------------------
module kctk_rank_cell import kctk_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rank_cmd_t cmd,
	input  wire logic      left_take,
	input  wire entry_t    left_entry,
	output      logic      take,
	output      entry_t    entry
);

	entry_t entry_q;

	// The ranking is sorted in descending count, so the cells that take form
	// a suffix of the chain. Ties keep the earlier document ahead.
	assign take = cmd.ins && (entry_q.cnt < cmd.entry.cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (cmd.clr) begin
			entry_q <= '0;
		end else if (take) begin
			entry_q <= left_take ? left_entry : cmd.entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ===== rtl/kctk_report_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kctk_report_cell: one stage of the report shift chain
// Loads a snapshot of one ranking slot and shifts toward the output as
// results are taken.
// ----------------------------------------------------------------------------
module kctk_report_cell import kctk_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire logic   load_vld,
	input  wire entry_t load_entry,
	input  wire logic   shift,
	input  wire logic   right_vld,
	input  wire entry_t right_entry,
	output      logic   vld,
	output      entry_t entry
);

	logic   vld_q;
	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= load_vld;
		end else if (shift) begin
			vld_q <= right_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
		end else if (shift) begin
			entry_q <= right_entry;
		end
	end

	assign vld   = vld_q;
	assign entry = entry_q;

endmodule
`default_nettype wire

// ===== rtl/keyword_count_top_k_ranker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_count_top_k_ranker: keyword counter with top-five document ranking
// Counts keyword hits per document and keeps a sorted ranking of documents.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per cycle: a text byte, an end of
//   document, or a report request. Text bytes and ends of document are taken
//   every cycle and produce no result; a document with a nonzero count is
//   placed into the ranking in the same cycle by the row of ranking cells.
//   A report copies the ranking into a shift chain and clears the ranking
//   and the document numbering. Its first result is valid the cycle after
//   the report item is accepted, and the chain delivers one result per cycle
//   while the output is ready.
//   The last result of each report is flagged by last. A report with no
//   ranked document gives a single result with found low.
//   While results of one report are still waiting, text bytes and ends of
//   document keep flowing; a second report is held off until the last result
//   of the first is taken, and may be accepted in that same cycle.
//   A stalled receiver simply holds the head of the chain.
//   Reset clears the counters, the ranking and the report chain at once and
//   sets the keyword length to one. Configuration writes take effect on the
//   next cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
module keyword_count_top_k_ranker import kctk_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire logic [OP_W-1:0]  opcode,
	input  wire logic [7:0]       text_byte,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic             found,
	output      logic [DOC_W-1:0] document_number,
	output      logic [CNT_W-1:0] match_count,
	output      logic             last
);

	logic [CFG_W-1:0] kw_low_q;
	logic [CFG_W-1:0] kw_high_q;
	logic [LEN_W-1:0] kw_len_q;
	logic [DOC_W-1:0] doc_cnt_q;
	logic [CNT_W-1:0] running_count;

	logic      in_acc;
	logic      is_text;
	logic      is_eod;
	logic      is_report;
	logic      doc_ok;
	logic      shift;
	rank_cmd_t cmd;

	logic   take_chain [TOP_K+1];
	entry_t rank_chain [TOP_K+1];
	logic   rep_vld    [TOP_K+1];
	entry_t rep_ent    [TOP_K+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_low_q  <= '0;
			kw_high_q <= '0;
			kw_len_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KW_LOW:  kw_low_q  <= cfg_data;
				REG_KW_HIGH: kw_high_q <= cfg_data;
				REG_KW_LEN:  kw_len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// A report may enter while the final result of the previous one leaves.
	assign in_ready  = !rep_vld[0] || (opcode != OP_REPORT) || (out_ready && !rep_vld[1]);
	assign in_acc    = in_valid && in_ready;
	assign is_text   = in_acc && (opcode == OP_TEXT);
	assign is_eod    = in_acc && (opcode == OP_EOD);
	assign is_report = in_acc && (opcode == OP_REPORT);
	assign doc_ok    = doc_cnt_q < DOC_LIMIT;

	kctk_matcher u_matcher (
		.clk           (clk),
		.arst_n        (arst_n),
		.keyword       ({kw_high_q, kw_low_q}),
		.keyword_len   (kw_len_q),
		.byte_en       (is_text),
		.byte_in       (text_byte),
		.doc_clr       (is_eod),
		.running_count (running_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_cnt_q <= '0;
		end else if (is_report) begin
			doc_cnt_q <= '0;
		end else if (is_eod && doc_ok) begin
			doc_cnt_q <= doc_cnt_q + DOC_W'(1);
		end
	end

	always_comb begin
		cmd.ins       = is_eod && doc_ok && (running_count != '0);
		cmd.clr       = is_report;
		cmd.entry.doc = doc_cnt_q + DOC_W'(1);
		cmd.entry.cnt = running_count;
	end

	assign take_chain[0] = 1'b0;
	assign rank_chain[0] = '0;
	assign rep_vld[TOP_K] = 1'b0;
	assign rep_ent[TOP_K] = '0;
	assign shift = out_valid && out_ready;

	for (genvar i = 0; i < TOP_K; i++) begin : g_cells
		logic load_vld;

		kctk_rank_cell u_rank (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_take  (take_chain[i]),
			.left_entry (rank_chain[i]),
			.take       (take_chain[i+1]),
			.entry      (rank_chain[i+1])
		);

		// The head always carries a result, the not-found one if empty.
		if (i == 0) begin : g_head
			assign load_vld = 1'b1;
		end else begin : g_tail
			assign load_vld = (rank_chain[i+1].cnt != '0);
		end

		kctk_report_cell u_report (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (is_report),
			.load_vld    (load_vld),
			.load_entry  (rank_chain[i+1]),
			.shift       (shift),
			.right_vld   (rep_vld[i+1]),
			.right_entry (rep_ent[i+1]),
			.vld         (rep_vld[i]),
			.entry       (rep_ent[i])
		);
	end

	assign out_valid       = rep_vld[0];
	assign found           = (rep_ent[0].cnt != '0);
	assign document_number = rep_ent[0].doc;
	assign match_count     = rep_ent[0].cnt;
	assign last            = !rep_vld[1];

	function automatic logic rank_sorted(input entry_t chain [TOP_K+1]);
		logic ok;
		ok = 1'b1;
		for (int k = 1; k < TOP_K; k++) begin
			if (chain[k].cnt < chain[k+1].cnt) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic logic rep_packed(input logic vld [TOP_K+1]);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < TOP_K; k++) begin
			if (!vld[k] && vld[k+1]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	a_rank_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		rank_sorted(rank_chain))
		else $error("ranking lost its descending order");

	a_rep_packed: assert property (@(posedge clk) disable iff (!arst_n)
		rep_packed(rep_vld))
		else $error("report chain has a gap");

	a_report_out: assert property (@(posedge clk) disable iff (!arst_n)
		is_report |=> out_valid && (rank_chain[1].cnt == '0) && (doc_cnt_q == '0))
		else $error("report did not load the chain and clear the ranking");

	a_eod_clear: assert property (@(posedge clk) disable iff (!arst_n)
		is_eod |=> (running_count == '0))
		else $error("end of document did not clear the count");

endmodule
`default_nettype wire
